// ===== rtl/ouks_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ouks_pkg
// Shared types, codes and defaults for the ordered unique key set.
// ----------------------------------------------------------------------------
package ouks_pkg;

  localparam int CAPACITY_DEF  = 16;
  localparam int KEY_CHARS_DEF = 8;
  localparam int KEY_W         = 64;
  localparam int REV_W         = 32;
  localparam int CMD_W         = 2;
  localparam int STAT_W        = 3;

  typedef enum logic [CMD_W-1:0] {
    CMD_ADD    = 2'd0,
    CMD_REMOVE = 2'd1,
    CMD_LOOKUP = 2'd2,
    CMD_CLEAR  = 2'd3
  } cmd_t;

  typedef enum logic [STAT_W-1:0] {
    STAT_OK        = 3'd0,
    STAT_INVALID   = 3'd1,
    STAT_EXISTS    = 3'd2,
    STAT_FULL      = 3'd3,
    STAT_NOT_FOUND = 3'd4
  } status_t;

  typedef enum logic {
    ST_IDLE  = 1'b0,
    ST_APPLY = 1'b1
  } state_t;

  // datapath -> controller
  typedef struct packed {
    cmd_t cmd;
    logic key_zero;
    logic hit;
    logic full;
  } dp_stat_t;

  // controller -> datapath
  typedef struct packed {
    logic    capture;
    logic    load;
    logic    do_append;
    logic    do_remove;
    logic    do_clear;
    status_t res_status;
    logic    res_found;
  } dp_cmd_t;

  // Mask of the key bits that carry characters
  function automatic logic [KEY_W-1:0] key_mask(input int chars);
    return {KEY_W{1'b1}} >> (KEY_W - 8 * chars);
  endfunction

endpackage

// ===== rtl/ouks_if.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ouks_if
// Valid/ready channels for commands in and results out.
// ----------------------------------------------------------------------------
interface ouks_in_if import ouks_pkg::*; ();
  logic               valid;
  logic               ready;
  logic [CMD_W-1:0]   command;
  logic [KEY_W-1:0]   key;

  modport source (output valid, output command, output key, input ready);
  modport sink   (input valid, input command, input key, output ready);
endinterface

interface ouks_out_if import ouks_pkg::*; #(
  parameter int CNT_W = 5
) ();
  logic               valid;
  logic               ready;
  logic [STAT_W-1:0]  status;
  logic               found;
  logic [CNT_W-1:0]   entry_count;
  logic [REV_W-1:0]   change_number;

  modport source (output valid, output status, output found, output entry_count,
                  output change_number, input ready);
  modport sink   (input valid, input status, input found, input entry_count,
                  input change_number, output ready);
endinterface

// ===== rtl/ouks_ctrl.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ouks_ctrl
// Command sequencer: capture/compare cycle, apply cycle, result handshake.
// ----------------------------------------------------------------------------
module ouks_ctrl import ouks_pkg::*; (
  input  logic     clk,
  input  logic     rst_n,
  input  logic     in_valid,
  output logic     in_ready,
  output logic     out_valid,
  input  logic     out_ready,
  input  dp_stat_t stat,
  output dp_cmd_t  cmd
);

  state_t state_r, state_nxt;
  logic   out_valid_r, out_valid_nxt;

  // state and result-valid registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // next state and datapath commands
  always_comb begin
    state_nxt      = state_r;
    cmd            = '0;
    cmd.res_status = STAT_OK;
    // result slot must be free by the apply cycle
    in_ready       = (state_r == ST_IDLE) && (!out_valid_r || out_ready);

    case (state_r)
      ST_IDLE: begin
        if (in_valid && in_ready) begin
          cmd.capture = 1'b1;
          state_nxt   = ST_APPLY;
        end
      end
      ST_APPLY: begin
        cmd.load  = 1'b1;
        state_nxt = ST_IDLE;
        case (stat.cmd)
          CMD_ADD: begin
            if (stat.key_zero) begin
              cmd.res_status = STAT_INVALID;
            end else if (stat.hit) begin
              cmd.res_status = STAT_EXISTS;
            end else if (stat.full) begin
              cmd.res_status = STAT_FULL;
            end else begin
              cmd.do_append = 1'b1;
            end
          end
          CMD_REMOVE: begin
            if (stat.hit) begin
              cmd.do_remove = 1'b1;
            end else begin
              cmd.res_status = STAT_NOT_FOUND;
            end
          end
          CMD_LOOKUP: begin
            cmd.res_found = stat.hit;
          end
          CMD_CLEAR: begin
            cmd.do_clear = 1'b1;
          end
          default: begin
            cmd.res_status = STAT_OK;
          end
        endcase
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase

    // hold a pending result until taken
    out_valid_nxt = cmd.load || (out_valid_r && !out_ready);
  end

  assign out_valid = out_valid_r;

endmodule

// ===== rtl/ouks_datapath.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ouks_datapath
// Key cells with parallel match, compacting shift, count, revision, result.
// ----------------------------------------------------------------------------
module ouks_datapath import ouks_pkg::*; #(
  parameter int CAPACITY  = CAPACITY_DEF,
  parameter int KEY_CHARS = KEY_CHARS_DEF,
  parameter int CNT_W     = $clog2(CAPACITY + 1)
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic [CMD_W-1:0]  in_command,
  input  logic [KEY_W-1:0]  in_key,
  input  dp_cmd_t           cmd,
  output dp_stat_t          stat,
  output logic [STAT_W-1:0] out_status,
  output logic              out_found,
  output logic [CNT_W-1:0]  out_entry_count,
  output logic [REV_W-1:0]  out_change_number
);

  localparam logic [KEY_W-1:0] KEY_MASK = key_mask(KEY_CHARS);
  localparam int               LVL      = $clog2(CAPACITY);
  localparam logic [CNT_W-1:0] CAP_CNT  = CNT_W'(CAPACITY);

  logic [KEY_W-1:0]    cells_r [CAPACITY];
  cmd_t                cmd_r;
  logic [KEY_W-1:0]    key_r;
  logic [CAPACITY-1:0] match_r, match_nxt;
  logic [CNT_W-1:0]    count_r, count_nxt;
  logic [REV_W-1:0]    rev_r, rev_nxt;
  logic [KEY_W-1:0]    key_in;
  logic [CAPACITY-1:0] pre [LVL+1];
  logic [CAPACITY-1:0] shift_en;

  logic [STAT_W-1:0]   res_status_r;
  logic                res_found_r;
  logic [CNT_W-1:0]    res_count_r;
  logic [REV_W-1:0]    res_rev_r;

  // parallel compare of the incoming key against live cells
  always_comb begin
    key_in = in_key & KEY_MASK;
    for (int i = 0; i < CAPACITY; i++) begin
      match_nxt[i] = (CNT_W'(i) < count_r) && (cells_r[i] == key_in) &&
                     (key_in != '0);
    end
  end

  // capture item and match vector
  always_ff @(posedge clk) begin
    if (cmd.capture) begin
      cmd_r   <= cmd_t'(in_command);
      key_r   <= key_in;
      match_r <= match_nxt;
    end
  end

  // prefix OR of matches: every cell at or above the hit takes its upper neighbor
  always_comb begin
    pre[0] = match_r;
    for (int l = 0; l < LVL; l++) begin
      for (int i = 0; i < CAPACITY; i++) begin
        if (i >= (1 << l)) begin
          pre[l+1][i] = pre[l][i] | pre[l][i - (1 << l)];
        end else begin
          pre[l+1][i] = pre[l][i];
        end
      end
    end
    shift_en = pre[LVL];
  end

  // status to controller
  always_comb begin
    stat.cmd      = cmd_r;
    stat.key_zero = (key_r == '0);
    stat.hit      = |match_r;
    stat.full     = (count_r == CAP_CNT);
  end

  // key cells: append at the tail, compact on remove
  for (genvar g = 0; g < CAPACITY; g++) begin : g_cell
    if (g < CAPACITY - 1) begin : g_mid
      always_ff @(posedge clk) begin
        if (cmd.do_append && (CNT_W'(g) == count_r)) begin
          cells_r[g] <= key_r;
        end else if (cmd.do_remove && shift_en[g]) begin
          cells_r[g] <= cells_r[g+1];
        end
      end
    end else begin : g_top
      always_ff @(posedge clk) begin
        if (cmd.do_append && (CNT_W'(g) == count_r)) begin
          cells_r[g] <= key_r;
        end
      end
    end
  end

  // count and revision after this command
  always_comb begin
    count_nxt = count_r;
    rev_nxt   = rev_r;
    if (cmd.do_clear) begin
      count_nxt = '0;
      rev_nxt   = '0;
    end else if (cmd.do_append) begin
      count_nxt = count_r + CNT_W'(1);
      rev_nxt   = rev_r + REV_W'(1);
    end else if (cmd.do_remove) begin
      count_nxt = count_r - CNT_W'(1);
      rev_nxt   = rev_r + REV_W'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      count_r <= '0;
      rev_r   <= '0;
    end else begin
      count_r <= count_nxt;
      rev_r   <= rev_nxt;
    end
  end

  // result register
  always_ff @(posedge clk) begin
    if (cmd.load) begin
      res_status_r <= cmd.res_status;
      res_found_r  <= cmd.res_found;
      res_count_r  <= count_nxt;
      res_rev_r    <= rev_nxt;
    end
  end

  assign out_status        = res_status_r;
  assign out_found         = res_found_r;
  assign out_entry_count   = res_count_r;
  assign out_change_number = res_rev_r;

endmodule

// ===== rtl/ordered_unique_key_set_core.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ordered_unique_key_set_core
// Ordered list of unique keys with add, remove, lookup and clear commands.
// ----------------------------------------------------------------------------
//  channel   dir  handshake     payload
//  in_chan   in   valid/ready   command[1:0], key[63:0]
//  out_chan  out  valid/ready   status[2:0], found, entry_count, change_number
//
//  Each item passes a capture step, which compares the key against all live
//  cells at once, and an apply step, which appends or compacts the cells and
//  loads the result register. The result is valid the cycle after the apply step.
//  Reset clears count, revision and control; the cells need no clearing pass.
//  A pending result holds in_ready low until it is taken or taken that cycle.
// ----------------------------------------------------------------------------
module ordered_unique_key_set_core import ouks_pkg::*; #(
  parameter int CAPACITY  = CAPACITY_DEF,
  parameter int KEY_CHARS = KEY_CHARS_DEF
) (
  input  logic       clk,
  input  logic       rst_n,
  ouks_in_if.sink    in_chan,
  ouks_out_if.source out_chan
);

  localparam int CNT_W = $clog2(CAPACITY + 1);

  dp_stat_t stat;
  dp_cmd_t  cmd;

  // sequencer
  ouks_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_chan.valid),
    .in_ready  (in_chan.ready),
    .out_valid (out_chan.valid),
    .out_ready (out_chan.ready),
    .stat      (stat),
    .cmd       (cmd)
  );

  // key cells and result
  ouks_datapath #(
    .CAPACITY  (CAPACITY),
    .KEY_CHARS (KEY_CHARS),
    .CNT_W     (CNT_W)
  ) u_dp (
    .clk               (clk),
    .rst_n             (rst_n),
    .in_command        (in_chan.command),
    .in_key            (in_chan.key),
    .cmd               (cmd),
    .stat              (stat),
    .out_status        (out_chan.status),
    .out_found         (out_chan.found),
    .out_entry_count   (out_chan.entry_count),
    .out_change_number (out_chan.change_number)
  );

endmodule

// ===== rtl/ouks_checker.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ouks_checker
// Port-level checks on the key set core, bound to the top level.
// ----------------------------------------------------------------------------
module ouks_checker import ouks_pkg::*; #(
  parameter int CAPACITY = CAPACITY_DEF,
  parameter int CNT_W    = $clog2(CAPACITY + 1)
) (
  input logic              clk,
  input logic              rst_n,
  input logic              in_valid,
  input logic              in_ready,
  input logic              out_valid,
  input logic              out_ready,
  input logic [STAT_W-1:0] out_status,
  input logic [CNT_W-1:0]  out_entry_count,
  input logic [REV_W-1:0]  out_change_number
);

  localparam logic [CNT_W-1:0] CAP_CNT = CNT_W'(CAPACITY);

  // count never passes capacity
  a_count_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (out_entry_count <= CAP_CNT))
    else $error("entry_count above capacity");

  // an accepted item yields a result after the apply cycle
  a_result_follows: assert property (@(posedge clk) disable iff (!rst_n)
    (in_valid && in_ready) |-> ##2 out_valid)
    else $error("no result after accepted item");

  // a full report means the list really is full
  a_full_count: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && (out_status == STAT_FULL)) |-> (out_entry_count == CAP_CNT))
    else $error("capacity exceeded with room left");

  // stalled result holds
  a_hold: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && !out_ready) |=>
      (out_valid && $stable(out_status) && $stable(out_entry_count) &&
       $stable(out_change_number)))
    else $error("stalled result changed");

endmodule

bind ordered_unique_key_set_core ouks_checker #(
  .CAPACITY (CAPACITY)
) u_ouks_checker (
  .clk               (clk),
  .rst_n             (rst_n),
  .in_valid          (in_chan.valid),
  .in_ready          (in_chan.ready),
  .out_valid         (out_chan.valid),
  .out_ready         (out_chan.ready),
  .out_status        (out_chan.status),
  .out_entry_count   (out_chan.entry_count),
  .out_change_number (out_chan.change_number)
);
